// ===== rtl/core/gn2d_pkg.sv =====
// Shared types and constants for the 2D gradient noise block.
// Holds field widths, fixed-point widths, action codes and the corner record.
// No dependencies.
package gn2d_pkg;

    // Field widths of the input and result items.
    localparam int CELL_W  = 6;
    localparam int GRAD_W  = 16;
    localparam int PT_W    = 24;
    localparam int FRAC_W  = 16;
    localparam int INT_W   = PT_W - FRAC_W;
    localparam int ENTRY_W = 2 * GRAD_W;
    localparam int NOISE_W = 16;

    // Datapath widths.
    localparam int DOT_W   = 34;              // dot products, row and column blends
    localparam int SQ_W    = 2 * FRAC_W;      // t squared
    localparam int CUBE_W  = 3 * FRAC_W;      // t cubed
    localparam int FV_W    = 51;              // fade polynomial before scaling
    localparam int FADE_W  = FRAC_W + 1;      // fade weight, 0 to 1.0 inclusive
    localparam int BL_W    = 52;              // blend accumulator
    localparam int ONE_Q16 = 2 ** FRAC_W;

    // Action codes.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    // Corner order: x varies fastest.
    localparam int NCORNER = 4;
    localparam int C00     = 0;
    localparam int C10     = 1;
    localparam int C01     = 2;
    localparam int C11     = 3;

    // Gradients of the four corners and the fractions of one evaluate.
    typedef struct packed {
        logic [NCORNER-1:0][ENTRY_W-1:0] grad;
        logic [FRAC_W-1:0]               tx;
        logic [FRAC_W-1:0]               ty;
    } corner_t;

endpackage

// ===== rtl/core/gn2d_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; contents are undefined until written.
// No dependencies.
module gn2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read ports; the read data holds while rd_en is low.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/gn2d_addr.sv =====
// Grid address generation for the 2D gradient noise block.
// Wraps cell indices modulo the grid size and forms the four corner addresses.
// Depends on gn2d_pkg.
module gn2d_addr #(
    parameter int  GRID_W = 64,
    parameter int  GRID_H = 64,
    localparam int AW     = $clog2(GRID_W * GRID_H)
) (
    input  logic                                       action,
    input  logic [gn2d_pkg::CELL_W-1:0]                cell_x,
    input  logic [gn2d_pkg::CELL_W-1:0]                cell_y,
    input  logic [gn2d_pkg::INT_W-1:0]                 int_x,
    input  logic [gn2d_pkg::INT_W-1:0]                 int_y,
    output logic [gn2d_pkg::NCORNER-1:0][AW-1:0]       corner_addr
);

    import gn2d_pkg::*;

    localparam int XW    = $clog2(GRID_W);
    localparam int YW    = $clog2(GRID_H);
    localparam int TAB_N = 2 ** INT_W;
    localparam logic [AW-1:0] GRID_W_A = AW'(GRID_W);

    logic [XW-1:0] xmod0_tab [TAB_N];
    logic [XW-1:0] xmod1_tab [TAB_N];
    logic [YW-1:0] ymod0_tab [TAB_N];
    logic [YW-1:0] ymod1_tab [TAB_N];

    logic [INT_W-1:0] ix_sel;
    logic [INT_W-1:0] iy_sel;
    logic [XW-1:0]    x0;
    logic [XW-1:0]    x1;
    logic [YW-1:0]    y0;
    logic [YW-1:0]    y1;
    logic [AW-1:0]    row0_base;
    logic [AW-1:0]    row1_base;

    // Constant wrap tables for a cell index and for its neighbor.
    for (genvar i = 0; i < TAB_N; i++) begin : g_tab
        assign xmod0_tab[i] = XW'(i % GRID_W);
        assign xmod1_tab[i] = XW'((i + 1) % GRID_W);
        assign ymod0_tab[i] = YW'(i % GRID_H);
        assign ymod1_tab[i] = YW'((i + 1) % GRID_H);
    end

    // A load uses its cell fields, an evaluate the integer part of its point.
    assign ix_sel = (action == ACT_EVAL) ? int_x : INT_W'(cell_x);
    assign iy_sel = (action == ACT_EVAL) ? int_y : INT_W'(cell_y);

    assign x0 = xmod0_tab[ix_sel];
    assign x1 = xmod1_tab[int_x];
    assign y0 = ymod0_tab[iy_sel];
    assign y1 = ymod1_tab[int_y];

    // Row-major addresses; the lower-left corner doubles as the load address.
    assign row0_base = AW'(y0) * GRID_W_A;
    assign row1_base = AW'(y1) * GRID_W_A;

    assign corner_addr[C00] = row0_base + AW'(x0);
    assign corner_addr[C10] = row0_base + AW'(x1);
    assign corner_addr[C01] = row1_base + AW'(x0);
    assign corner_addr[C11] = row1_base + AW'(x1);

endmodule

// ===== rtl/core/gn2d_arith.sv =====
// Arithmetic pipeline of the 2D gradient noise block.
// Dot products, smoothstep fade, bilinear blend, rounding and saturation.
// Depends on gn2d_pkg.
module gn2d_arith (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  gn2d_pkg::corner_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [gn2d_pkg::NOISE_W-1:0] out_noise
);

    import gn2d_pkg::*;

    // Stages: dot, cube, fade, row blend, column blend, output.
    localparam int NSTG = 6;
    localparam int ST_DOT  = 0;
    localparam int ST_CUBE = 1;
    localparam int ST_FADE = 2;
    localparam int ST_ROW  = 3;
    localparam int ST_COL  = 4;
    localparam int ST_OUT  = 5;
    localparam int RW = DOT_W - FRAC_W;
    localparam logic signed [BL_W-1:0]  BL_HALF  = BL_W'(2 ** (FRAC_W - 1));
    localparam logic signed [DOT_W-1:0] OUT_HALF = DOT_W'(2 ** (FRAC_W - 1));
    localparam logic signed [RW-1:0]    SAT_HI   = RW'(2 ** (NOISE_W - 1) - 1);
    localparam logic signed [RW-1:0]    SAT_LO   = RW'(-(2 ** (NOISE_W - 1)));

    // Gradient at one corner dotted with the offset from that corner.
    function automatic logic signed [DOT_W-1:0] corner_dot(
        input logic        [ENTRY_W-1:0] g,
        input logic signed [FRAC_W:0]    ox,
        input logic signed [FRAC_W:0]    oy
    );
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic signed [DOT_W-2:0]  px;
        logic signed [DOT_W-2:0]  py;
        gx = g[GRAD_W-1:0];
        gy = g[ENTRY_W-1:GRAD_W];
        px = gx * ox;
        py = gy * oy;
        return DOT_W'(px) + DOT_W'(py);
    endfunction

    // Fade 3t^2 - 2t^3 in Q0.16, rounded half up.
    function automatic logic [FADE_W-1:0] fade(
        input logic [SQ_W-1:0]   sq,
        input logic [CUBE_W-1:0] cb
    );
        logic [FV_W-1:0] v;
        v = (FV_W'(sq) << (FRAC_W + 1)) + (FV_W'(sq) << FRAC_W)
            - (FV_W'(cb) << 1) + (FV_W'(1) << (2 * FRAC_W - 1));
        return FADE_W'(v >> (2 * FRAC_W));
    endfunction

    // a*(1-s) + b*s, rounded half up to the input scale.
    function automatic logic signed [DOT_W-1:0] blend(
        input logic signed [DOT_W-1:0] a,
        input logic signed [DOT_W-1:0] b,
        input logic        [FADE_W-1:0] s
    );
        logic signed [FADE_W:0] wa;
        logic signed [FADE_W:0] wb;
        logic signed [BL_W-1:0] pa;
        logic signed [BL_W-1:0] pb;
        logic signed [BL_W-1:0] acc;
        wa  = $signed({1'b0, FADE_W'(ONE_Q16 - int'(s))});
        wb  = $signed({1'b0, s});
        pa  = a * wa;
        pb  = b * wb;
        acc = pa + pb + BL_HALF;
        return DOT_W'(acc >>> FRAC_W);
    endfunction

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    logic signed [FRAC_W:0] ox0, ox1, oy0, oy1;

    logic signed [DOT_W-1:0]  dot_next [NCORNER];
    logic signed [DOT_W-1:0]  dot_a_reg [NCORNER];
    logic signed [DOT_W-1:0]  dot_b_reg [NCORNER];
    logic signed [DOT_W-1:0]  dot_c_reg [NCORNER];
    logic [SQ_W-1:0]          sqx_next, sqy_next;
    logic [SQ_W-1:0]          sqx_a_reg, sqy_a_reg, sqx_b_reg, sqy_b_reg;
    logic [FRAC_W-1:0]        tx_a_reg, ty_a_reg;
    logic [CUBE_W-1:0]        cbx_next, cby_next, cbx_reg, cby_reg;
    logic [FADE_W-1:0]        sx_next, sy_next, sx_reg, sy_reg, sy_d_reg;
    logic signed [DOT_W-1:0]  row0_next, row1_next, row0_reg, row1_reg;
    logic signed [DOT_W-1:0]  col_next, col_reg;
    logic signed [DOT_W-1:0]  rnd_sum;
    logic signed [RW-1:0]     rnd;
    logic signed [NOISE_W-1:0] noise_next, noise_reg;

    // Stage enables: a stage moves when it is empty or the next one moves.
    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (en[0]) begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[ST_DOT];
    assign out_valid = vld_reg[ST_OUT];
    assign out_noise = noise_reg;

    // Corner offsets: t and t - 1.0.
    assign ox0 = $signed({1'b0, in_data.tx});
    assign ox1 = $signed({1'b1, in_data.tx});
    assign oy0 = $signed({1'b0, in_data.ty});
    assign oy1 = $signed({1'b1, in_data.ty});

    // Dot products and squares of the fractions.
    assign dot_next[C00] = corner_dot(in_data.grad[C00], ox0, oy0);
    assign dot_next[C10] = corner_dot(in_data.grad[C10], ox1, oy0);
    assign dot_next[C01] = corner_dot(in_data.grad[C01], ox0, oy1);
    assign dot_next[C11] = corner_dot(in_data.grad[C11], ox1, oy1);
    assign sqx_next = SQ_W'(in_data.tx) * SQ_W'(in_data.tx);
    assign sqy_next = SQ_W'(in_data.ty) * SQ_W'(in_data.ty);

    // Cubes of the fractions.
    assign cbx_next = CUBE_W'(sqx_a_reg) * CUBE_W'(tx_a_reg);
    assign cby_next = CUBE_W'(sqy_a_reg) * CUBE_W'(ty_a_reg);

    // Fade weights.
    assign sx_next = fade(sqx_b_reg, cbx_reg);
    assign sy_next = fade(sqy_b_reg, cby_reg);

    // Blend along x on both rows, then along y.
    assign row0_next = blend(dot_c_reg[C00], dot_c_reg[C10], sx_reg);
    assign row1_next = blend(dot_c_reg[C01], dot_c_reg[C11], sx_reg);
    assign col_next  = blend(row0_reg, row1_reg, sy_d_reg);

    // Round to Q1.14 and saturate.
    assign rnd_sum = col_reg + OUT_HALF;
    assign rnd     = RW'(rnd_sum >>> FRAC_W);

    always_comb begin
        if (rnd > SAT_HI) begin
            noise_next = NOISE_W'(SAT_HI);
        end else if (rnd < SAT_LO) begin
            noise_next = NOISE_W'(SAT_LO);
        end else begin
            noise_next = NOISE_W'(rnd);
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge aclk) begin
        if (en[ST_DOT]) begin
            for (int c = 0; c < NCORNER; c++) begin
                dot_a_reg[c] <= dot_next[c];
            end
            sqx_a_reg <= sqx_next;
            sqy_a_reg <= sqy_next;
            tx_a_reg  <= in_data.tx;
            ty_a_reg  <= in_data.ty;
        end
        if (en[ST_CUBE]) begin
            for (int c = 0; c < NCORNER; c++) begin
                dot_b_reg[c] <= dot_a_reg[c];
            end
            sqx_b_reg <= sqx_a_reg;
            sqy_b_reg <= sqy_a_reg;
            cbx_reg   <= cbx_next;
            cby_reg   <= cby_next;
        end
        if (en[ST_FADE]) begin
            for (int c = 0; c < NCORNER; c++) begin
                dot_c_reg[c] <= dot_b_reg[c];
            end
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        if (en[ST_ROW]) begin
            row0_reg <= row0_next;
            row1_reg <= row1_next;
            sy_d_reg <= sy_reg;
        end
        if (en[ST_COL]) begin
            col_reg <= col_next;
        end
        if (en[ST_OUT]) begin
            noise_reg <= noise_next;
        end
    end

endmodule

// ===== rtl/core/gradient_noise_2d.sv =====
// 2D gradient noise: an evaluate passes the input register, the memory read stage and
// the arithmetic pipeline before m_valid rises; loads give no result. Sustained rate
// is one item per cycle while m_ready stays high; four copies of the gradient grid,
// each read once per cycle for one corner, feed a fully pipelined arithmetic datapath.
// Reset (aresetn, synchronous, active low) clears only the pipeline valid flags;
// the gradient memories keep undefined contents until written by load items.
module gradient_noise_2d #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [gn2d_pkg::CELL_W-1:0]         s_cell_x,
    input  logic [gn2d_pkg::CELL_W-1:0]         s_cell_y,
    input  logic signed [gn2d_pkg::GRAD_W-1:0]  s_grad_x,
    input  logic signed [gn2d_pkg::GRAD_W-1:0]  s_grad_y,
    input  logic [gn2d_pkg::PT_W-1:0]           s_point_x,
    input  logic [gn2d_pkg::PT_W-1:0]           s_point_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [gn2d_pkg::NOISE_W-1:0] m_noise_value
);

    import gn2d_pkg::*;

    localparam int DEPTH = GRID_W * GRID_H;
    localparam int AW    = $clog2(DEPTH);

    logic                  in_vld_reg;
    logic                  act_reg;
    logic [CELL_W-1:0]     cellx_reg, celly_reg;
    logic [ENTRY_W-1:0]    grad_reg;
    logic [PT_W-1:0]       ptx_reg, pty_reg;
    logic                  rd_vld_reg;
    logic [FRAC_W-1:0]     tx_reg, ty_reg;
    logic                  en_in, en_rd;
    logic                  arith_ready;
    logic                  ram_wr, ram_rd;
    logic [NCORNER-1:0][AW-1:0]      corner_addr;
    logic [NCORNER-1:0][ENTRY_W-1:0] corner_grad;
    corner_t               corner_data;

    // Stage enables for the input register and the memory read stage.
    assign en_rd   = !rd_vld_reg || arith_ready;
    assign en_in   = !in_vld_reg || en_rd;
    assign s_ready = en_in;

    // Input register: one transfer per cycle while the stage ahead keeps moving.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en_in) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && en_in) begin
            act_reg   <= s_action;
            cellx_reg <= s_cell_x;
            celly_reg <= s_cell_y;
            grad_reg  <= {s_grad_y, s_grad_x};
            ptx_reg   <= s_point_x;
            pty_reg   <= s_point_y;
        end
    end

    // Corner and load addresses.
    gn2d_addr #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_addr (
        .action      (act_reg),
        .cell_x      (cellx_reg),
        .cell_y      (celly_reg),
        .int_x       (ptx_reg[PT_W-1:FRAC_W]),
        .int_y       (pty_reg[PT_W-1:FRAC_W]),
        .corner_addr (corner_addr)
    );

    // Loads write every copy and evaluates read all four, in arrival order at
    // one stage, so a read always sees every earlier write.
    assign ram_wr = en_rd && in_vld_reg && (act_reg == ACT_LOAD);
    assign ram_rd = en_rd && in_vld_reg && (act_reg == ACT_EVAL);

    for (genvar c = 0; c < NCORNER; c++) begin : g_ram
        gn2d_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (ram_wr),
            .wr_addr (corner_addr[C00]),
            .wr_data (grad_reg),
            .rd_en   (ram_rd),
            .rd_addr (corner_addr[c]),
            .rd_data (corner_grad[c])
        );
    end

    // Read stage: only evaluates continue down the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else if (en_rd) begin
            rd_vld_reg <= in_vld_reg && (act_reg == ACT_EVAL);
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_rd) begin
            tx_reg <= ptx_reg[FRAC_W-1:0];
            ty_reg <= pty_reg[FRAC_W-1:0];
        end
    end

    assign corner_data.grad = corner_grad;
    assign corner_data.tx   = tx_reg;
    assign corner_data.ty   = ty_reg;

    // Dot products, fade and blend.
    gn2d_arith u_arith (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_vld_reg),
        .in_ready  (arith_ready),
        .in_data   (corner_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_noise (m_noise_value)
    );

endmodule

// ===== rtl/core/gn2d_checker.sv =====
// Port-level assertions for the 2D gradient noise block.
// Bound to gradient_noise_2d; depends on gn2d_pkg.
module gn2d_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [gn2d_pkg::NOISE_W-1:0] m_noise_value
);

    // Reset empties the pipeline, so no result is offered right after it.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // With the result side ready, nothing in the pipeline stalls the input.
    a_full_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while result side is ready");

    // A stalled result keeps its valid and its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_noise_value))
        else $error("stalled result changed");

    // Out of reset, the handshake outputs are always known.
    a_accept_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_ready, m_valid}))
        else $error("handshake output unknown");

endmodule

bind gradient_noise_2d gn2d_checker u_gn2d_checker (.*);

// ===== tb/gradient_noise_2d_test.sv =====
// Self-checking testbench for gradient_noise_2d: gradient loads and noise evaluates
// with random pacing on both valid/ready channels, checked against a built-in predictor.
// Depends on gn2d_pkg and the gradient_noise_2d RTL.
module gradient_noise_2d_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gn2d_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int GRID_W      = 64;
    localparam int GRID_H      = 64;
    localparam int GRID_CELLS  = GRID_W * GRID_H;
    localparam int ITEMS_TOTAL = 1150;
    localparam int MAX_GAP     = 14;
    localparam int DRAIN_TAIL  = 24;
    localparam int SHOW_LIMIT  = 10;

    // One input transfer, plus an optional hand-computed expectation.
    typedef struct packed {
        logic                       action;
        logic [CELL_W-1:0]          cell_x;
        logic [CELL_W-1:0]          cell_y;
        logic signed [GRAD_W-1:0]   grad_x;
        logic signed [GRAD_W-1:0]   grad_y;
        logic [PT_W-1:0]            point_x;
        logic [PT_W-1:0]            point_y;
        logic                       has_known;
        logic signed [NOISE_W-1:0]  known_noise;
    } noise_item_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_action = ACT_LOAD;
    logic [CELL_W-1:0]          s_cell_x = '0;
    logic [CELL_W-1:0]          s_cell_y = '0;
    logic signed [GRAD_W-1:0]   s_grad_x = '0;
    logic signed [GRAD_W-1:0]   s_grad_y = '0;
    logic [PT_W-1:0]            s_point_x = '0;
    logic [PT_W-1:0]            s_point_y = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [NOISE_W-1:0]  m_noise_value;

    // Shadow copy of the gradient grid and which entries hold a written value.
    logic signed [GRAD_W-1:0]   shadow_gx [GRID_CELLS];
    logic signed [GRAD_W-1:0]   shadow_gy [GRID_CELLS];
    bit                         cell_loaded [GRID_CELLS];

    logic signed [NOISE_W-1:0]  pending_noise_q [$];
    noise_item_t                directed_plan [$];

    bit tx_pacing_on = 1'b1;
    bit rx_pacing_on = 1'b1;
    int mismatch_cnt = 0;
    int load_cnt     = 0;
    int eval_cnt     = 0;
    int result_cnt   = 0;

    gradient_noise_2d #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_cell_x      (s_cell_x),
        .s_cell_y      (s_cell_y),
        .s_grad_x      (s_grad_x),
        .s_grad_y      (s_grad_y),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_noise_value (m_noise_value)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Gradient dotted with the offset from its corner, in Q.30.
    function automatic longint corner_dot(input int unsigned cx, input int unsigned cy,
                                          input longint ox, input longint oy);
        longint gx;
        longint gy;
        gx = shadow_gx[(cy * GRID_W + cx) % GRID_CELLS];
        gy = shadow_gy[(cy * GRID_W + cx) % GRID_CELLS];
        return gx * ox + gy * oy;
    endfunction

    // Smoothstep weight 3t^2 - 2t^3 in Q0.16, rounded half up.
    function automatic longint fade_weight(input longint t);
        longint unsigned t2;
        longint unsigned poly;
        t2   = t * t;
        poly = 3 * t2 * ONE_Q16 - 2 * t2 * t;
        return longint'((poly + (64'd1 << 31)) >> 32);
    endfunction

    // Divide by 2^16 with rounding toward plus infinity on ties.
    function automatic longint round_q16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint mix(input longint a, input longint b, input longint s);
        return round_q16(a * (ONE_Q16 - s) + b * s);
    endfunction

    // Expected noise at a Q8.16 point, from the shadow grid.
    function automatic logic signed [NOISE_W-1:0] noise_at(input logic [PT_W-1:0] px,
                                                           input logic [PT_W-1:0] py);
        int unsigned x0, x1, y0, y1;
        longint tx, ty, sx, sy, row0, row1, acc;
        x0   = px[PT_W-1:FRAC_W] % GRID_W;
        x1   = (px[PT_W-1:FRAC_W] + 1) % GRID_W;
        y0   = py[PT_W-1:FRAC_W] % GRID_H;
        y1   = (py[PT_W-1:FRAC_W] + 1) % GRID_H;
        tx   = px[FRAC_W-1:0];
        ty   = py[FRAC_W-1:0];
        sx   = fade_weight(tx);
        sy   = fade_weight(ty);
        row0 = mix(corner_dot(x0, y0, tx, ty), corner_dot(x1, y0, tx - ONE_Q16, ty), sx);
        row1 = mix(corner_dot(x0, y1, tx, ty - ONE_Q16),
                   corner_dot(x1, y1, tx - ONE_Q16, ty - ONE_Q16), sx);
        acc  = round_q16(mix(row0, row1, sy));
        if (acc > 32767)
            acc = 32767;
        if (acc < -32768)
            acc = -32768;
        return acc[NOISE_W-1:0];
    endfunction

    // A load carries random point fields, which the block must ignore.
    function automatic noise_item_t load_row(input int cx, input int cy,
                                             input int gx, input int gy);
        noise_item_t it;
        it.action      = ACT_LOAD;
        it.cell_x      = cx[CELL_W-1:0];
        it.cell_y      = cy[CELL_W-1:0];
        it.grad_x      = gx[GRAD_W-1:0];
        it.grad_y      = gy[GRAD_W-1:0];
        it.point_x     = PT_W'($urandom);
        it.point_y     = PT_W'($urandom);
        it.has_known   = 1'b0;
        it.known_noise = '0;
        return it;
    endfunction

    // An evaluate carries random cell and gradient fields, which the block must ignore.
    function automatic noise_item_t eval_row(input logic [PT_W-1:0] px,
                                             input logic [PT_W-1:0] py,
                                             input bit known, input int noise);
        noise_item_t it;
        it.action      = ACT_EVAL;
        it.cell_x      = CELL_W'($urandom);
        it.cell_y      = CELL_W'($urandom);
        it.grad_x      = GRAD_W'($urandom);
        it.grad_y      = GRAD_W'($urandom);
        it.point_x     = px;
        it.point_y     = py;
        it.has_known   = known;
        it.known_noise = noise[NOISE_W-1:0];
        return it;
    endfunction

    // Mostly in the stated range, now and then the out-of-range minimum.
    function automatic int rand_grad();
        if ($urandom_range(15, 0) == 0)
            return -32768;
        return int'($urandom_range(32768, 0)) - 16384;
    endfunction

    // Present one item, wait for its transfer, then update the prediction.
    task automatic send_item(input noise_item_t it);
        int gap;
        int idx;
        gap = tx_pacing_on ? $urandom_range(MAX_GAP, 0) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_action  <= it.action;
        s_cell_x  <= it.cell_x;
        s_cell_y  <= it.cell_y;
        s_grad_x  <= it.grad_x;
        s_grad_y  <= it.grad_y;
        s_point_x <= it.point_x;
        s_point_y <= it.point_y;
        do @(posedge aclk); while (!s_ready);
        if (it.action == ACT_LOAD) begin
            idx              = (it.cell_y % GRID_H) * GRID_W + (it.cell_x % GRID_W);
            shadow_gx[idx]   = it.grad_x;
            shadow_gy[idx]   = it.grad_y;
            cell_loaded[idx] = 1'b1;
            load_cnt++;
        end else begin
            pending_noise_q.push_back(it.has_known ? it.known_noise
                                                   : noise_at(it.point_x, it.point_y));
            eval_cnt++;
        end
    endtask

    // Withdraw the input and wait until every expected result has come.
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_noise_q.size() != 0)
            @(posedge aclk);
    endtask

    // Result side: a random stall before each result, then hold ready until it comes.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = rx_pacing_on ? $urandom_range(MAX_GAP, 0) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge aclk) begin : result_check
        logic signed [NOISE_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            result_cnt++;
            if (pending_noise_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= SHOW_LIMIT)
                    $display("[%0t] unexpected result: noise_value=%0d", $realtime,
                             m_noise_value);
            end else begin
                want = pending_noise_q.pop_front();
                if (m_noise_value !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= SHOW_LIMIT)
                        $display("[%0t] noise_value mismatch: expected %0d, got %0d",
                                 $realtime, want, m_noise_value);
                end
            end
        end
    end

    // Stimulus: directed table, then random traffic, then drain and report.
    initial begin
        noise_item_t it;
        logic [PT_W-1:0] px, py;
        int unsigned xs [2];
        int unsigned ys [2];
        int sent;
        bit drained_mid;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Corner cells around the origin and around the wrap edge of the grid,
        // with unit, zero and out-of-range gradient components.
        directed_plan.push_back(load_row(0, 0, 16384, 16384));
        directed_plan.push_back(load_row(1, 0, -16384, 16384));
        directed_plan.push_back(load_row(0, 1, 16384, -16384));
        directed_plan.push_back(load_row(1, 1, -32768, -32768));
        directed_plan.push_back(load_row(63, 0, 0, 16384));
        directed_plan.push_back(load_row(63, 1, -16384, 0));
        directed_plan.push_back(load_row(0, 63, 16384, 0));
        directed_plan.push_back(load_row(1, 63, -32768, 16384));
        directed_plan.push_back(load_row(63, 63, 0, -32768));
        // Integer points sit on a corner, so the noise there is zero.
        directed_plan.push_back(eval_row(24'h000000, 24'h000000, 1'b1, 0));
        directed_plan.push_back(eval_row(24'h3F0000, 24'h3F0000, 1'b1, 0));
        directed_plan.push_back(eval_row(24'hFF0000, 24'h000000, 1'b1, 0));
        // Fraction extremes, cell centers, and integer parts that wrap.
        directed_plan.push_back(eval_row(24'h00FFFF, 24'h00FFFF, 1'b0, 0));
        directed_plan.push_back(eval_row(24'h008000, 24'h008000, 1'b0, 0));
        directed_plan.push_back(eval_row(24'hFFFFFF, 24'hFFFFFF, 1'b0, 0));
        directed_plan.push_back(eval_row(24'h3F8000, 24'h000001, 1'b0, 0));
        directed_plan.push_back(eval_row(24'h00C000, 24'hFF4000, 1'b0, 0));
        directed_plan.push_back(eval_row(24'h000001, 24'h00FFFF, 1'b0, 0));
        // Overwrite a corner and read it back right away.
        directed_plan.push_back(load_row(0, 0, -32768, -32768));
        directed_plan.push_back(eval_row(24'h004000, 24'h004000, 1'b0, 0));
        directed_plan.push_back(eval_row(24'h00A000, 24'h006000, 1'b0, 0));

        foreach (directed_plan[i])
            send_item(directed_plan[i]);

        // Let the pipeline run dry once before the random traffic.
        wait_for_results();

        sent        = load_cnt + eval_cnt;
        drained_mid = 1'b0;
        while (load_cnt + eval_cnt < ITEMS_TOTAL) begin
            // Switch the pacing of both sides every hundred items or so.
            if ((load_cnt + eval_cnt) / 100 != sent / 100) begin
                tx_pacing_on = 1'($urandom_range(1, 0));
                rx_pacing_on = 1'($urandom_range(1, 0));
            end
            sent = load_cnt + eval_cnt;
            if (!drained_mid && sent >= ITEMS_TOTAL / 2) begin
                drained_mid = 1'b1;
                wait_for_results();
            end

            if ($urandom_range(99, 0) < 25) begin
                // Stray load anywhere in the grid, often replacing a written entry.
                send_item(load_row($urandom_range(63, 0), $urandom_range(63, 0),
                                   rand_grad(), rand_grad()));
            end else begin
                px = PT_W'($urandom);
                py = PT_W'($urandom);
                if ($urandom_range(4, 0) == 0)
                    px[FRAC_W-1:0] = ($urandom_range(1, 0) != 0) ? 16'hFFFF : 16'h0000;
                if ($urandom_range(4, 0) == 0)
                    py[FRAC_W-1:0] = ($urandom_range(1, 0) != 0) ? 16'h8000 : 16'h0001;
                xs[0] = px[PT_W-1:FRAC_W] % GRID_W;
                xs[1] = (px[PT_W-1:FRAC_W] + 1) % GRID_W;
                ys[0] = py[PT_W-1:FRAC_W] % GRID_H;
                ys[1] = (py[PT_W-1:FRAC_W] + 1) % GRID_H;
                // Fill any corner that was never written before reading it.
                foreach (ys[j])
                    foreach (xs[k])
                        if (!cell_loaded[ys[j] * GRID_W + xs[k]])
                            send_item(load_row(xs[k], ys[j], rand_grad(), rand_grad()));
                send_item(eval_row(px, py, 1'b0, 0));
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("Covered %0d gradient loads and %0d evaluates; %0d results checked.",
                 load_cnt, eval_cnt, result_cnt);
        $display("Points spanned the full Q8.16 range with cell wrap on both axes.");
        if (mismatch_cnt == 0 && pending_noise_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("Failures: %0d, results still outstanding: %0d", mismatch_cnt,
                     pending_noise_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding.", pending_noise_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/gn2d_pkg.sv
rtl/core/gn2d_ram.sv
rtl/core/gn2d_addr.sv
rtl/core/gn2d_arith.sv
rtl/core/gradient_noise_2d.sv
rtl/core/gn2d_checker.sv
tb/gradient_noise_2d_test.sv
